// ===== hw/rtl/fms_pkg.sv =====
// Shared types, constants and helpers for the fuzzy match scorer.
package fms_pkg;

	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned CFG_W        = 64;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned LEN_W        = 5;
	localparam int unsigned HAY_W        = 8;
	localparam int unsigned SUB_POS_W    = 7;
	localparam int unsigned ANCHOR_W     = 6;
	localparam int unsigned RUN_W        = 4;
	localparam int unsigned SCORE_W      = 10;
	localparam int unsigned TIER_W       = 3;
	localparam int unsigned NEEDLE_BYTES = 16;
	localparam int unsigned BONUS_W      = 7;

	localparam logic [HAY_W-1:0]     HAY_SAT     = 8'd255;
	localparam logic [SUB_POS_W-1:0] SUB_POS_SAT = 7'd80;
	localparam logic [ANCHOR_W-1:0]  ANCHOR_SAT  = 6'd40;
	localparam logic [RUN_W-1:0]     RUN_SAT     = 4'd15;

	localparam logic [SCORE_W-1:0] SCORE_EXACT  = 10'd1000;
	localparam logic [SCORE_W-1:0] SCORE_PREFIX = 10'd800;
	localparam logic [SCORE_W-1:0] SCORE_SUBSTR = 10'd600;
	localparam logic [SCORE_W-1:0] SCORE_SUBSEQ = 10'd200;
	localparam int                 BONUS_BASE   = 64;
	localparam int                 FUZZY_CAP    = 120;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEEDLE_LOW  = 3'd0,
		CFG_NEEDLE_HIGH = 3'd1,
		CFG_NEEDLE_LEN  = 3'd2,
		CFG_FUZZY_EN    = 3'd3,
		CFG_CASE_FOLD   = 3'd4
	} cfg_idx_t;

	typedef enum logic [TIER_W-1:0] {
		TIER_NONE   = 3'd0,
		TIER_EXACT  = 3'd1,
		TIER_PREFIX = 3'd2,
		TIER_SUBSTR = 3'd3,
		TIER_SUBSEQ = 3'd4
	} tier_t;

	typedef struct packed {
		logic take;
		logic clear;
		logic seq_adv;
	} cell_ctrl_t;

	typedef struct packed {
		logic hit;
		logic pre;
		logic seq;
	} cell_link_t;

	typedef struct packed {
		logic full;
		logic pre_miss;
		logic seq_hit;
	} cell_flags_t;

	typedef struct packed {
		logic [LEN_W-1:0]     n;
		logic                 prefix_ok;
		logic [HAY_W-1:0]     hay_len;
		logic                 sub_found;
		logic [SUB_POS_W-1:0] sub_pos;
		logic                 seq_done;
		logic                 fuzzy;
		logic [ANCHOR_W-1:0]  anchor;
		logic [RUN_W-1:0]     run;
	} snap_t;

	typedef struct packed {
		logic               matched;
		tier_t              tier;
		logic [SCORE_W-1:0] score;
	} res_t;

	function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c, input logic en);
		logic [BYTE_W-1:0] r;
		r = c;
		if (en && c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/fms_in_if.sv =====
// Haystack byte channel: valid/ready handshake with at most one byte per item.
interface fms_in_if import fms_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] ch;
	logic              last;
	logic              empty_item;

	modport source(output valid, ch, last, empty_item, input ready);
	modport sink(input valid, ch, last, empty_item, output ready);
endinterface

// ===== hw/rtl/fms_out_if.sv =====
// Score result channel: valid/ready handshake carrying tier and score.
interface fms_out_if import fms_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               matched;
	logic [TIER_W-1:0]  tier;
	logic [SCORE_W-1:0] score;

	modport source(output valid, matched, tier, score, input ready);
	modport sink(input valid, matched, tier, score, output ready);
endinterface

// ===== hw/rtl/fms_cell.sv =====
// One query position: byte compare, partial-match bit and position tokens.
module fms_cell import fms_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] qbyte,
	input  logic [BYTE_W-1:0] ch,
	input  logic [LEN_W-1:0]  n,
	input  cell_ctrl_t        ctrl,
	input  cell_link_t        link_in,
	output cell_link_t        link_out,
	output cell_flags_t       flags
);

	logic hit_q;
	logic pre_q;
	logic seq_q;
	logic active;
	logic is_last;
	logic eq;
	logic new_hit;

	assign active   = IDX < 32'(n);
	assign is_last  = (IDX + 1) == 32'(n);
	assign eq       = active && (qbyte == ch);
	assign new_hit  = link_in.hit && eq;

	assign flags.full     = is_last && new_hit;
	assign flags.pre_miss = pre_q && active && !eq;
	assign flags.seq_hit  = seq_q && eq;

	assign link_out.hit = hit_q;
	assign link_out.pre = pre_q;
	assign link_out.seq = seq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			pre_q <= (IDX == 0);
			seq_q <= (IDX == 0);
		end else if (ctrl.clear) begin
			hit_q <= 1'b0;
			pre_q <= (IDX == 0);
			seq_q <= (IDX == 0);
		end else if (ctrl.take) begin
			hit_q <= new_hit;
			pre_q <= link_in.pre;
			if (ctrl.seq_adv) begin
				seq_q <= link_in.seq;
			end
		end
	end

endmodule

// ===== hw/rtl/fuzzy_match_scorer.sv =====
// Top level of the fuzzy match scorer: cell row, scan state and result pipeline.
//
// Takes one haystack byte per cycle while hay.ready is high and emits one
// result item for each item marked last. Every byte is compared against all
// query positions at once by a row of NEEDLE_MAX cells, each of which keeps its
// partial-match bit and hands it, with the prefix position token, to its
// neighbor on every byte; the subsequence token moves only on a subsequence
// hit. The scan state is cleared in the same cycle that the last byte is taken,
// so the next haystack may start right behind it. The score is formed in a
// second stage from a snapshot of the scan state. Input ready drops only while
// both the snapshot stage and the output register hold results that have not
// been taken. Configuration is written through cfg_we, cfg_idx and cfg_wdata
// and must only change while no haystack is in flight.
module fuzzy_match_scorer import fms_pkg::*; #(
	parameter int unsigned NEEDLE_MAX = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	fms_in_if.sink               hay,
	fms_out_if.source            result
);

	logic [2*CFG_W-1:0] needle_q;
	logic [LEN_W-1:0]   needle_len_q;
	logic               fuzzy_q;
	logic               fold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_q     <= '0;
			needle_len_q <= '0;
			fuzzy_q      <= 1'b0;
			fold_q       <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_NEEDLE_LOW:  needle_q[CFG_W-1:0]       <= cfg_wdata;
				CFG_NEEDLE_HIGH: needle_q[2*CFG_W-1:CFG_W] <= cfg_wdata;
				CFG_NEEDLE_LEN:  needle_len_q              <= cfg_wdata[LEN_W-1:0];
				CFG_FUZZY_EN:    fuzzy_q                   <= cfg_wdata[0];
				CFG_CASE_FOLD:   fold_q                    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	logic [LEN_W-1:0]  n;
	logic [BYTE_W-1:0] chf;

	assign n   = (32'(needle_len_q) > NEEDLE_MAX) ? LEN_W'(NEEDLE_MAX) : needle_len_q;
	assign chf = fold(hay.ch, fold_q);

	logic s1_vld_q;
	logic out_vld_q;
	logic out_free;
	logic s1_move;
	logic acc;
	logic take;
	logic fin;

	assign out_free  = !out_vld_q || result.ready;
	assign s1_move   = s1_vld_q && out_free;
	assign hay.ready = !s1_vld_q || out_free;
	assign acc       = hay.valid && hay.ready;
	assign take      = acc && !hay.empty_item;
	assign fin       = acc && hay.last;

	cell_ctrl_t             ctrl;
	cell_link_t             links [NEEDLE_MAX];
	cell_flags_t            flags [NEEDLE_MAX];
	logic [NEEDLE_MAX-1:0]  full_v;
	logic [NEEDLE_MAX-1:0]  miss_v;
	logic [NEEDLE_MAX-1:0]  shit_v;
	logic [NEEDLE_MAX-1:0]  pre_v;
	logic [NEEDLE_MAX-1:0]  seq_v;
	logic                   seq_hit;

	assign seq_hit      = |shit_v;
	assign ctrl.take    = take;
	assign ctrl.clear   = fin;
	assign ctrl.seq_adv = seq_hit;

	for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_cell
		logic [BYTE_W-1:0] qb;
		cell_link_t        lin;

		if (j < NEEDLE_BYTES) begin : g_byte
			assign qb = fold(needle_q[BYTE_W*j +: BYTE_W], fold_q);
		end else begin : g_zero
			assign qb = '0;
		end

		if (j == 0) begin : g_head
			assign lin = '{hit: 1'b1, pre: 1'b0, seq: 1'b0};
		end else begin : g_body
			assign lin = links[j-1];
		end

		fms_cell #(
			.IDX(j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.qbyte   (qb),
			.ch      (chf),
			.n       (n),
			.ctrl    (ctrl),
			.link_in (lin),
			.link_out(links[j]),
			.flags   (flags[j])
		);

		assign full_v[j] = flags[j].full;
		assign miss_v[j] = flags[j].pre_miss;
		assign shit_v[j] = flags[j].seq_hit;
		assign pre_v[j]  = links[j].pre;
		assign seq_v[j]  = links[j].seq;
	end

	logic                 prefix_ok_q;
	logic [HAY_W-1:0]     hay_len_q;
	logic                 sub_found_q;
	logic [SUB_POS_W-1:0] sub_pos_q;
	logic [LEN_W-1:0]     seq_cnt_q;
	logic                 first_seen_q;
	logic [ANCHOR_W-1:0]  anchor_q;
	logic                 prev_hit_q;
	logic [RUN_W-1:0]     run_q;

	logic                 prefix_ok_d;
	logic [HAY_W-1:0]     hay_len_d;
	logic                 sub_found_d;
	logic [SUB_POS_W-1:0] sub_pos_d;
	logic [LEN_W-1:0]     seq_cnt_d;
	logic                 first_seen_d;
	logic [ANCHOR_W-1:0]  anchor_d;
	logic                 prev_hit_d;
	logic [RUN_W-1:0]     run_d;
	logic [HAY_W:0]       hp1;
	logic [HAY_W:0]       nn;
	logic [HAY_W:0]       pos;

	assign hp1 = {1'b0, hay_len_q} + 9'd1;
	assign nn  = {4'b0, n};
	assign pos = (hp1 >= nn) ? (hp1 - nn) : '0;

	always_comb begin
		prefix_ok_d  = prefix_ok_q;
		hay_len_d    = hay_len_q;
		sub_found_d  = sub_found_q;
		sub_pos_d    = sub_pos_q;
		seq_cnt_d    = seq_cnt_q;
		first_seen_d = first_seen_q;
		anchor_d     = anchor_q;
		prev_hit_d   = prev_hit_q;
		run_d        = run_q;
		if (take) begin
			if ((|full_v) && !sub_found_q) begin
				sub_found_d = 1'b1;
				sub_pos_d   = (pos > 9'(SUB_POS_SAT)) ? SUB_POS_SAT : pos[SUB_POS_W-1:0];
			end
			if (|miss_v) begin
				prefix_ok_d = 1'b0;
			end
			if (seq_hit) begin
				if (!first_seen_q) begin
					first_seen_d = 1'b1;
					anchor_d     = (hay_len_q > 8'(ANCHOR_SAT)) ? ANCHOR_SAT
						: hay_len_q[ANCHOR_W-1:0];
				end
				if (prev_hit_q && run_q != RUN_SAT) begin
					run_d = run_q + 4'd1;
				end
				seq_cnt_d = seq_cnt_q + 5'd1;
			end
			prev_hit_d = seq_hit;
			if (hay_len_q != HAY_SAT) begin
				hay_len_d = hay_len_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_ok_q  <= 1'b1;
			hay_len_q    <= '0;
			sub_found_q  <= 1'b0;
			sub_pos_q    <= '0;
			seq_cnt_q    <= '0;
			first_seen_q <= 1'b0;
			anchor_q     <= '0;
			prev_hit_q   <= 1'b0;
			run_q        <= '0;
		end else if (fin) begin
			prefix_ok_q  <= 1'b1;
			hay_len_q    <= '0;
			sub_found_q  <= 1'b0;
			sub_pos_q    <= '0;
			seq_cnt_q    <= '0;
			first_seen_q <= 1'b0;
			anchor_q     <= '0;
			prev_hit_q   <= 1'b0;
			run_q        <= '0;
		end else begin
			prefix_ok_q  <= prefix_ok_d;
			hay_len_q    <= hay_len_d;
			sub_found_q  <= sub_found_d;
			sub_pos_q    <= sub_pos_d;
			seq_cnt_q    <= seq_cnt_d;
			first_seen_q <= first_seen_d;
			anchor_q     <= anchor_d;
			prev_hit_q   <= prev_hit_d;
			run_q        <= run_d;
		end
	end

	snap_t snap_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (fin) begin
			s1_vld_q <= 1'b1;
		end else if (s1_move) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			snap_s1.n         <= n;
			snap_s1.prefix_ok <= prefix_ok_d;
			snap_s1.hay_len   <= hay_len_d;
			snap_s1.sub_found <= sub_found_d;
			snap_s1.sub_pos   <= sub_pos_d;
			snap_s1.seq_done  <= (seq_cnt_d == n);
			snap_s1.fuzzy     <= fuzzy_q;
			snap_s1.anchor    <= anchor_d;
			snap_s1.run       <= run_d;
		end
	end

	res_t                res_d;
	res_t                res_q;
	logic signed [9:0]   diff;
	logic signed [9:0]   bon_raw;
	logic [BONUS_W-1:0]  bonus;
	logic signed [8:0]   fz_raw;
	logic [BONUS_W-1:0]  fz_bonus;

	assign diff    = $signed({2'b0, snap_s1.hay_len}) - $signed({5'b0, snap_s1.n});
	assign bon_raw = 10'(BONUS_BASE) - diff;
	assign bonus   = (bon_raw < 0) ? '0 : bon_raw[BONUS_W-1:0];
	assign fz_raw  = $signed({2'b0, snap_s1.run, 3'b0}) - $signed({3'b0, snap_s1.anchor});
	assign fz_bonus = (fz_raw < 0) ? '0
		: (fz_raw > 9'(FUZZY_CAP)) ? BONUS_W'(FUZZY_CAP) : fz_raw[BONUS_W-1:0];

	always_comb begin
		res_d = '{matched: 1'b0, tier: TIER_NONE, score: '0};
		if (snap_s1.n == '0) begin
			res_d = '{matched: 1'b1, tier: TIER_PREFIX, score: '0};
		end else if (snap_s1.prefix_ok && snap_s1.hay_len == 8'(snap_s1.n)) begin
			res_d = '{matched: 1'b1, tier: TIER_EXACT, score: SCORE_EXACT};
		end else if (snap_s1.prefix_ok && snap_s1.hay_len >= 8'(snap_s1.n)) begin
			res_d = '{matched: 1'b1, tier: TIER_PREFIX,
				score: SCORE_PREFIX + 10'(bonus)};
		end else if (snap_s1.sub_found) begin
			res_d = '{matched: 1'b1, tier: TIER_SUBSTR,
				score: SCORE_SUBSTR - 10'(snap_s1.sub_pos) + 10'(bonus)};
		end else if (snap_s1.fuzzy && snap_s1.seq_done) begin
			res_d = '{matched: 1'b1, tier: TIER_SUBSEQ,
				score: SCORE_SUBSEQ + 10'(fz_bonus)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_move) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_q <= res_d;
		end
	end

	assign result.valid   = out_vld_q;
	assign result.matched = res_q.matched;
	assign result.tier    = res_q.tier;
	assign result.score   = res_q.score;

`ifndef SYNTHESIS
	a_pre_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pre_v))
		else $error("prefix token not one-hot");

	a_seq_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(seq_v))
		else $error("subsequence token not one-hot");

	a_unmatched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !res_q.matched |-> res_q.tier == TIER_NONE && res_q.score == '0)
		else $error("unmatched result carries tier or score");

	a_last_snap: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> s1_vld_q)
		else $error("last item did not load the snapshot stage");

	a_scan_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> hay_len_q == '0 && prefix_ok_q && seq_cnt_q == '0)
		else $error("scan state not cleared after last item");
`endif

endmodule
